FILE: design/retry_deadline_session_tracker_core_assert.svh
// Assertion macros for the session tracker module rdst_session.
`ifndef RETRY_DEADLINE_SESSION_TRACKER_CORE_ASSERT_SVH
`define RETRY_DEADLINE_SESSION_TRACKER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("session tracker check failed");

// The consequent must hold in the cycle after the antecedent.
`define RDST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("session tracker check failed");

`endif

FILE: design/rdst_pkg.sv
`timescale 1ns / 1ps

package rdst_pkg;

    // Field widths.
    localparam int CNT_W    = 16;
    localparam int TMO_W    = 40;
    localparam int TIME_W   = 64;
    localparam int CODE_W   = 32;
    localparam int STAT_W   = 3;
    localparam int KIND_W   = 2;
    localparam int ACT_W    = 2;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 40;

    // Operation codes; code 7 is unused and behaves as an outcome query.
    typedef enum logic [2:0] {
        OP_BEGIN      = 3'd0,
        OP_BEGIN_TMO  = 3'd1,
        OP_NEXT       = 3'd2,
        OP_RETRY      = 3'd3,
        OP_COMPLETE   = 3'd4,
        OP_OUTCOME    = 3'd5,
        OP_RESET      = 3'd6
    } op_t;

    // Session status codes.
    localparam logic [STAT_W-1:0] ST_COMPLETED = 3'd0;
    localparam logic [STAT_W-1:0] ST_TIMEOUT   = 3'd1;
    localparam logic [STAT_W-1:0] ST_INVALID   = 3'd4;

    // Policy kinds.
    localparam logic [KIND_W-1:0] KIND_POLL    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PROCESS = 2'd3;

    // Failure actions.
    localparam logic [ACT_W-1:0] ACT_FAIL = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SKIP = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_ATTEMPT_LIMIT   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_ATTEMPT_TIMEOUT = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_TOTAL_TIMEOUT   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_POLICY_KIND     = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_FAILURE_ACTION  = 3'd4;

    // Configuration reset values.
    localparam logic [CNT_W-1:0]  RST_ATTEMPT_LIMIT   = 16'd8;
    localparam logic [TMO_W-1:0]  RST_ATTEMPT_TIMEOUT = 40'd100000000;
    localparam logic [TMO_W-1:0]  RST_TOTAL_TIMEOUT   = 40'd800000000;
    localparam logic [KIND_W-1:0] RST_POLICY_KIND     = 2'd0;
    localparam logic [ACT_W-1:0]  RST_FAILURE_ACTION  = 2'd0;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [CNT_W-1:0]  attempt_limit;
        logic [TMO_W-1:0]  attempt_timeout;
        logic [TMO_W-1:0]  total_timeout;
        logic [KIND_W-1:0] policy_kind;
        logic [ACT_W-1:0]  failure_action;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [TIME_W-1:0]  now_time;
        logic [TMO_W-1:0]   requested_timeout;
        logic [CODE_W-1:0]  native_code;
        logic [STAT_W-1:0]  final_status;
    } item_t;

    typedef struct packed {
        logic               accepted;
        logic [TIME_W-1:0]  attempt_budget;
        logic [STAT_W-1:0]  session_status;
        logic [ACT_W-1:0]   action_out;
        logic [CNT_W-1:0]   attempts_out;
        logic [TIME_W-1:0]  elapsed_time;
        logic [CODE_W-1:0]  native_out;
        logic               active_out;
    } result_t;

endpackage

FILE: design/rdst_cfg_regs.sv
`timescale 1ns / 1ps

module rdst_cfg_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [rdst_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [rdst_pkg::CFG_DW-1:0] cfg_wdata,
    output rdst_pkg::cfg_t             cfg
);
    import rdst_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_ATTEMPT_LIMIT:   cfg_next.attempt_limit   = cfg_wdata[CNT_W-1:0];
                CFG_ATTEMPT_TIMEOUT: cfg_next.attempt_timeout = cfg_wdata[TMO_W-1:0];
                CFG_TOTAL_TIMEOUT:   cfg_next.total_timeout   = cfg_wdata[TMO_W-1:0];
                CFG_POLICY_KIND:     cfg_next.policy_kind     = cfg_wdata[KIND_W-1:0];
                CFG_FAILURE_ACTION:  cfg_next.failure_action  = cfg_wdata[ACT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attempt_limit   <= RST_ATTEMPT_LIMIT;
            cfg_reg.attempt_timeout <= RST_ATTEMPT_TIMEOUT;
            cfg_reg.total_timeout   <= RST_TOTAL_TIMEOUT;
            cfg_reg.policy_kind     <= RST_POLICY_KIND;
            cfg_reg.failure_action  <= RST_FAILURE_ACTION;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/rdst_in_stage.sv
`timescale 1ns / 1ps

module rdst_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  rdst_pkg::item_t in_item,
    input  logic            out_ready,
    output logic            fire,
    output rdst_pkg::item_t item
);
    import rdst_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // The held request moves on whenever the result register can load.
    assign fire     = valid_reg && out_ready;
    assign in_stall = valid_reg && !fire;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        priority if (take)
            valid_next = 1'b1;
        else if (fire)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Request payload register.
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= in_item;
    end

    assign item = item_reg;

endmodule

FILE: design/rdst_session.sv
`timescale 1ns / 1ps

module rdst_session
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  rdst_pkg::item_t   item,
    input  rdst_pkg::cfg_t    cfg,
    output rdst_pkg::result_t res
);
    import rdst_pkg::*;

    `include "retry_deadline_session_tracker_core_assert.svh"

    logic [TIME_W-1:0] deadline_reg, deadline_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0]  attempt_cnt_reg, attempt_cnt_next;
    logic              active_reg, active_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [CODE_W-1:0] native_reg, native_next;

    logic              policy_valid;
    logic              begin_ok;
    logic [TMO_W-1:0]  req_tmo;
    logic [TMO_W-1:0]  bounded_tmo;
    logic [TIME_W:0]   deadline_sum;
    logic [TIME_W-1:0] deadline_sat;
    logic              past_deadline;
    logic [TIME_W-1:0] remaining;
    logic              tt_nonzero;
    logic              at_le_rem;
    logic [TIME_W-1:0] at_wide;
    logic              accepted;
    logic [TIME_W-1:0] budget;

    // Policy checks and the bounded session timeout.
    always_comb
    begin
        tt_nonzero   = (cfg.total_timeout != '0);
        policy_valid = (cfg.attempt_limit != '0) &&
                       !(((cfg.policy_kind == KIND_POLL) || (cfg.policy_kind == KIND_PROCESS)) &&
                         ((cfg.attempt_timeout == '0) || (cfg.total_timeout == '0)));
        begin_ok     = policy_valid &&
                       !((item.op == OP_BEGIN_TMO) && (cfg.policy_kind == KIND_PROCESS) &&
                         (item.requested_timeout == '0));
        req_tmo      = (item.op == OP_BEGIN) ? cfg.total_timeout : item.requested_timeout;
        bounded_tmo  = (tt_nonzero && (cfg.total_timeout < req_tmo)) ?
                       cfg.total_timeout : req_tmo;
        deadline_sum = {1'b0, item.now_time} + {{(TIME_W + 1 - TMO_W){1'b0}}, bounded_tmo};
        deadline_sat = deadline_sum[TIME_W] ? TIME_MAX : deadline_sum[TIME_W-1:0];
    end

    // Time left before the deadline and the per-attempt grant.
    always_comb
    begin
        past_deadline = (item.now_time >= deadline_reg);
        remaining     = past_deadline ? '0 : (deadline_reg - item.now_time);
        at_wide       = {{(TIME_W - TMO_W){1'b0}}, cfg.attempt_timeout};
        at_le_rem     = (at_wide < remaining);
    end

    // Session state update for one request.
    always_comb
    begin
        deadline_next    = deadline_reg;
        start_next       = start_reg;
        attempt_cnt_next = attempt_cnt_reg;
        active_next      = active_reg;
        status_next      = status_reg;
        native_next      = native_reg;
        accepted         = 1'b0;
        budget           = '0;
        unique case (item.op)
            OP_BEGIN, OP_BEGIN_TMO:
            begin
                if (begin_ok)
                begin
                    deadline_next    = deadline_sat;
                    start_next       = item.now_time;
                    attempt_cnt_next = '0;
                    native_next      = '0;
                    status_next      = ST_TIMEOUT;
                    active_next      = 1'b1;
                    accepted         = 1'b1;
                end
            end
            OP_NEXT:
            begin
                if (active_reg && (attempt_cnt_reg < cfg.attempt_limit) &&
                    !(tt_nonzero && (remaining == '0)))
                begin
                    attempt_cnt_next = attempt_cnt_reg + 1'b1;
                    accepted         = 1'b1;
                    if (cfg.attempt_timeout == '0)
                        budget = TIME_MAX;
                    else
                        budget = at_le_rem ? at_wide : remaining;
                end
            end
            OP_RETRY:
            begin
                if (active_reg)
                begin
                    native_next = item.native_code;
                    if ((attempt_cnt_reg >= cfg.attempt_limit) || (tt_nonzero && past_deadline))
                    begin
                        active_next = 1'b0;
                        status_next = ST_TIMEOUT;
                    end
                    else
                    begin
                        accepted = 1'b1;
                    end
                end
            end
            OP_COMPLETE:
            begin
                status_next = (item.final_status > ST_INVALID) ? ST_INVALID : item.final_status;
                native_next = item.native_code;
                active_next = 1'b0;
            end
            OP_RESET:
            begin
                deadline_next    = '0;
                start_next       = '0;
                attempt_cnt_next = '0;
                active_next      = 1'b0;
                status_next      = ST_COMPLETED;
                native_next      = '0;
            end
            OP_OUTCOME:
            begin
                accepted = 1'b0;
            end
            default:
            begin
                accepted = 1'b0;
            end
        endcase
    end

    // Result fields reflect the state after the request.
    always_comb
    begin
        res.accepted       = accepted;
        res.attempt_budget = budget;
        res.session_status = status_next;
        res.action_out     = (cfg.failure_action > ACT_SKIP) ? ACT_FAIL : cfg.failure_action;
        res.attempts_out   = attempt_cnt_next;
        res.elapsed_time   = (item.now_time > start_next) ? (item.now_time - start_next) : '0;
        res.native_out     = native_next;
        res.active_out     = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadline_reg    <= '0;
            start_reg       <= '0;
            attempt_cnt_reg <= '0;
            active_reg      <= 1'b0;
            status_reg      <= ST_COMPLETED;
            native_reg      <= '0;
        end
        else if (fire)
        begin
            deadline_reg    <= deadline_next;
            start_reg       <= start_next;
            attempt_cnt_reg <= attempt_cnt_next;
            active_reg      <= active_next;
            status_reg      <= status_next;
            native_reg      <= native_next;
        end
    end

    // Session state only moves when a request is processed.
    `RDST_ASSERT_NEXT(a_cnt_hold, clk, rst_n, !fire, $stable(attempt_cnt_reg))
    `RDST_ASSERT_NEXT(a_cnt_step, clk, rst_n, fire && (item.op == OP_NEXT) && accepted, attempt_cnt_reg == ($past(attempt_cnt_reg) + 16'd1))
    `RDST_ASSERT_NEXT(a_complete_ends, clk, rst_n, fire && (item.op == OP_COMPLETE), !active_reg)

endmodule

FILE: design/rdst_out_stage.sv
`timescale 1ns / 1ps

module rdst_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  rdst_pkg::result_t res_in,
    input  logic              out_stall,
    output logic              out_ready,
    output logic              out_valid,
    output rdst_pkg::result_t res_out
);
    import rdst_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // The result register can load when empty or being drained.
    assign out_ready = !valid_reg || !out_stall;

    always_comb
    begin
        priority if (fire)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_in;
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

FILE: design/retry_deadline_session_tracker_core.sv
// A request waits in the request register until the result register can load.
// Throughput: one request per cycle while out_stall is low; the session update
// is one pass of compares, one 64-bit add and subtracts between the request
// register and the result register. Reset clears the session state and the valid
// flags of both pipeline registers and loads the default policy configuration.
`timescale 1ns / 1ps

module retry_deadline_session_tracker_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    operation,
    input  logic [rdst_pkg::TIME_W-1:0]   now_time,
    input  logic [rdst_pkg::TMO_W-1:0]    requested_timeout,
    input  logic [rdst_pkg::CODE_W-1:0]   native_code,
    input  logic [rdst_pkg::STAT_W-1:0]   final_status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          accepted,
    output logic [rdst_pkg::TIME_W-1:0]   attempt_budget,
    output logic [rdst_pkg::STAT_W-1:0]   session_status,
    output logic [rdst_pkg::ACT_W-1:0]    action_out,
    output logic [rdst_pkg::CNT_W-1:0]    attempts_out,
    output logic [rdst_pkg::TIME_W-1:0]   elapsed_time,
    output logic [rdst_pkg::CODE_W-1:0]   native_out,
    output logic                          active_out,
    input  logic                          cfg_wr_en,
    input  logic [rdst_pkg::CFG_AW-1:0]   cfg_addr,
    input  logic [rdst_pkg::CFG_DW-1:0]   cfg_wdata
);
    import rdst_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    result_t res;
    result_t res_out;
    logic    fire;
    logic    out_ready;

    // Pack the request fields.
    always_comb
    begin
        in_item.op                = op_t'(operation);
        in_item.now_time          = now_time;
        in_item.requested_timeout = requested_timeout;
        in_item.native_code       = native_code;
        in_item.final_status      = final_status;
    end

    rdst_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rdst_in_stage u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_ready (out_ready),
        .fire      (fire),
        .item      (item)
    );

    rdst_session u_session
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item),
        .cfg   (cfg),
        .res   (res)
    );

    rdst_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res_in    (res),
        .out_stall (out_stall),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    // Unpack the result fields.
    assign accepted       = res_out.accepted;
    assign attempt_budget = res_out.attempt_budget;
    assign session_status = res_out.session_status;
    assign action_out     = res_out.action_out;
    assign attempts_out   = res_out.attempts_out;
    assign elapsed_time   = res_out.elapsed_time;
    assign native_out     = res_out.native_out;
    assign active_out     = res_out.active_out;

endmodule
